FILE: hw/rtl/bgd_pkg.sv
`default_nettype none
package bgd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int THR_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [THR_W-1:0]       thr_t;
  typedef logic [1:0]             ev_t;
  typedef logic [2:0]             phase_t;
  typedef logic [1:0]             reg_idx_t;

  localparam ev_t EV_NONE   = 2'd0;
  localparam ev_t EV_CLICK  = 2'd1;
  localparam ev_t EV_DOUBLE = 2'd2;
  localparam ev_t EV_LONG   = 2'd3;

  localparam phase_t PH_IDLE      = 3'd0;
  localparam phase_t PH_DOWN_DEB  = 3'd1;
  localparam phase_t PH_PRESSED   = 3'd2;
  localparam phase_t PH_UP_DEB    = 3'd3;
  localparam phase_t PH_WAIT_2ND  = 3'd4;
  localparam phase_t PH_DOWN2_DEB = 3'd5;
  localparam phase_t PH_WAIT_REL  = 3'd6;

  localparam reg_idx_t REG_DEBOUNCE   = 2'd0;
  localparam reg_idx_t REG_LONG_PRESS = 2'd1;
  localparam reg_idx_t REG_DOUBLE_GAP = 2'd2;

  localparam thr_t DEBOUNCE_RST   = THR_W'(20);
  localparam thr_t LONG_PRESS_RST = THR_W'(1000);
  localparam thr_t DOUBLE_GAP_RST = THR_W'(300);

  typedef struct packed {
    thr_t debounce_ticks;
    thr_t long_press_ticks;
    thr_t double_gap_ticks;
  } cfg_t;

  typedef struct packed {
    ev_t  event_code;
    logic from_read;
  } result_t;

  typedef struct packed {
    phase_t phase;
    ev_t    held_event;
  } status_t;

  function automatic logic reaches(input count_t cnt, input thr_t thr);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(cnt);
    b = CMP_W'(thr);
    return a >= b;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bgd_cfg.sv
`default_nettype none
module bgd_cfg (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [bgd_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [bgd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bgd_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                        cfg_pready,
  output bgd_pkg::cfg_t               cfg
);
  import bgd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx        = cfg_paddr[3:2];
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.double_gap_ticks <= DOUBLE_GAP_RST;
    end else if (wr) begin
      unique case (idx)
        REG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_pwdata[THR_W-1:0];
        REG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_pwdata[THR_W-1:0];
        REG_DOUBLE_GAP: cfg_r.double_gap_ticks <= cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE:   cfg_prdata = DATA_W'(cfg_r.debounce_ticks);
      REG_LONG_PRESS: cfg_prdata = DATA_W'(cfg_r.long_press_ticks);
      REG_DOUBLE_GAP: cfg_prdata = DATA_W'(cfg_r.double_gap_ticks);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bgd_core.sv
`default_nettype none
module bgd_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bgd_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  input  wire logic              in_kind,
  input  wire logic              in_pin,
  output logic                   in_ready,
  input  wire logic              out_free,
  output logic                   res_valid,
  output bgd_pkg::result_t       res,
  output bgd_pkg::status_t       sts
);
  import bgd_pkg::*;

  logic   s1_valid_r, s1_valid_nxt;
  logic   s1_kind_r;
  logic   s1_pin_r;
  phase_t phase_r, phase_nxt;
  count_t cnt_r, cnt_nxt;
  ev_t    held_r, held_nxt;
  ev_t    ev;
  count_t bumped;
  logic   down;
  logic   load;
  logic   adv;

  assign in_ready  = !s1_valid_r || out_free;
  assign load      = in_valid && in_ready;
  assign adv       = s1_valid_r && out_free;
  assign res_valid = s1_valid_r;
  assign sts       = '{phase: phase_r, held_event: held_r};

  assign down   = !s1_pin_r;
  assign bumped = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + count_t'(1);

  always_comb begin
    s1_valid_nxt = load ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  end

  always_comb begin
    ev        = EV_NONE;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    if (s1_kind_r) begin
      held_nxt = EV_NONE;
    end else begin
      unique case (phase_r)
        PH_DOWN_DEB: begin
          cnt_nxt = bumped;
          if (reaches(bumped, cfg.debounce_ticks)) begin
            phase_nxt = down ? PH_PRESSED : PH_IDLE;
            if (down) begin
              cnt_nxt = '0;
            end
          end
        end
        PH_PRESSED: begin
          cnt_nxt = bumped;
          if (reaches(bumped, cfg.long_press_ticks)) begin
            ev        = EV_LONG;
            phase_nxt = PH_WAIT_REL;
            cnt_nxt   = '0;
          end else if (!down) begin
            phase_nxt = PH_UP_DEB;
            cnt_nxt   = '0;
          end
        end
        PH_UP_DEB: begin
          cnt_nxt = bumped;
          if (reaches(bumped, cfg.debounce_ticks)) begin
            phase_nxt = down ? PH_PRESSED : PH_WAIT_2ND;
            cnt_nxt   = '0;
          end
        end
        PH_WAIT_2ND: begin
          if (down) begin
            phase_nxt = PH_DOWN2_DEB;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = bumped;
            if (reaches(bumped, cfg.double_gap_ticks)) begin
              ev        = EV_CLICK;
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_DOWN2_DEB: begin
          cnt_nxt = bumped;
          if (reaches(bumped, cfg.debounce_ticks)) begin
            if (down) begin
              ev        = EV_DOUBLE;
              phase_nxt = PH_WAIT_REL;
            end else begin
              phase_nxt = PH_WAIT_2ND;
            end
            cnt_nxt = '0;
          end
        end
        PH_WAIT_REL: begin
          if (!down) begin
            cnt_nxt = bumped;
            if (reaches(bumped, cfg.debounce_ticks)) begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
            end
          end else begin
            cnt_nxt = '0;
          end
        end
        default: begin
          if (down) begin
            phase_nxt = PH_DOWN_DEB;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
      if (ev != EV_NONE) begin
        held_nxt = ev;
      end
    end
  end

  assign res.event_code = s1_kind_r ? held_r : ev;
  assign res.from_read  = s1_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      held_r     <= EV_NONE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (adv) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_kind_r <= in_kind;
      s1_pin_r  <= in_pin;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/button_gesture_detector.sv
// Push-button gesture detector for an active-low pin.
// Input channel: one item per tick (tuser = 0, tdata[0] = pin level) or a
// read of the held event (tuser = 1). Every item yields exactly one result
// item: tdata[1:0] holds the event code (none, click, double click, long
// press) and tuser[0] is set when the result answers a read.
// Timing thresholds are set through the APB port and are meant to be
// changed only while no item is in flight.
// A result item is registered on its way out: the item first waits in the
// input register, and the gesture machine and its tick counter are updated
// as it moves into the result register.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item before in_tready drops.
// Reset is synchronous: thresholds return to 20, 1000 and 300 ticks, the
// machine goes idle with a cleared counter and no held event, and both
// registers are emptied.
`default_nettype none
module button_gesture_detector (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [0] pin_level
  input  wire logic [0:0]                 in_tuser,   // [0] kind
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata,  // [1:0] event_code
  output logic [0:0]                      out_tuser,  // [0] from_read
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [bgd_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [bgd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bgd_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import bgd_pkg::*;

  cfg_t    cfg;
  result_t res;
  status_t sts;
  logic    res_valid;
  logic    out_free;
  logic    out_valid_r;
  result_t out_res_r;

  assign out_free = !out_valid_r || out_tready;

  bgd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bgd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser[0]),
    .in_pin    (in_tdata[0]),
    .in_ready  (in_tready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .sts       (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.event_code};
  assign out_tuser  = out_res_r.from_read;

`ifndef ASSERT_OFF
  a_read_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_free && res.from_read) |=> (sts.held_event == EV_NONE))
    else $error("held event not cleared after a read");

  a_tick_event_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_free && !res.from_read && res.event_code != EV_NONE)
      |=> (sts.held_event == $past(res.event_code)))
    else $error("raised event not stored in the held slot");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while result register is empty");

  a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_free) |=> out_tvalid)
    else $error("processed item did not reach the result register");
`endif

endmodule
`default_nettype wire
